// ----- sv/ssz_pkg.sv -----
// ----------------------------------------------------------------------------
// ssz_pkg
// Shared types and constants for the square splat z-buffer rasteriser.
// ----------------------------------------------------------------------------
package ssz_pkg;

  // Command modes carried by an input beat
  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LIGHT_X = 3'd0;
  localparam logic [2:0] CFG_LIGHT_Y = 3'd1;
  localparam logic [2:0] CFG_LIGHT_Z = 3'd2;
  localparam logic [2:0] CFG_FRAME_W = 3'd3;
  localparam logic [2:0] CFG_FRAME_H = 3'd4;
  localparam logic [2:0] CFG_FLIP_Y  = 3'd5;

  // Lighting and colour scale factors
  localparam logic [17:0] AMBIENT_Q16 = 18'd3277;
  localparam int          DIFFUSE_Q16 = 55706;
  localparam int          CHAN_SCALE  = 65533;
  localparam int          GREY_SCALE  = 15099494;

  // Index of the last colour channel (blue)
  localparam logic [1:0] CH_LAST = 2'd2;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_SPAN,
    OP_DOT_X,
    OP_DOT_Y,
    OP_DOT_Z,
    OP_DOT_SUM,
    OP_DIFF,
    OP_LIGHT,
    OP_CH_MUL,
    OP_CH_SCALE,
    OP_CH_SAT,
    OP_GREY_MUL,
    OP_GREY_SAT,
    OP_PIX_RD,
    OP_PIX_WR,
    OP_RD_ISSUE,
    OP_RES_ZERO,
    OP_RES_REJ,
    OP_RES_CNT,
    OP_RES_RD
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] ch;
  } dp_cmd_t;

  typedef struct packed {
    logic rej;
    logic has_color;
    logic pix_last;
    logic clr_last;
  } dp_sts_t;

endpackage

// ----- sv/square_splat_zbuffer_raster.sv -----
// ----------------------------------------------------------------------------
// square_splat_zbuffer_raster
// Z-buffered square splat rasteriser with on-chip colour and depth stores.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid_i / in_stall_o | mode, position, depth, size, normal,
//           |                        | colour
//  result   | out_valid_o/out_stall_i | pixels_written, rejected, colour, depth
//  config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A draw, with colour or in grey, ends with a read-then-write of the pixel
//  store entry of each covered pixel. A clear sweeps the stores, one store entry
//  per cycle. After reset the same clearing pass runs before the first input
//  beat is taken; config writes are taken throughout.
//  One command is in flight at a time; a new beat is taken while the last
//  result beat still waits on out_stall_i, and finishing waits for it.
// ----------------------------------------------------------------------------
module square_splat_zbuffer_raster #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24,
  parameter int MAX_SPLAT  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [24:0] depth_z_i,
  input  logic [9:0]         splat_size_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic               has_color_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [10:0]        pixels_written_o,
  output logic               rejected_o,
  output logic [31:0]        pixel_color_o,
  output logic [23:0]        pixel_depth_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import ssz_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;

  ssz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ssz_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS),
    .MAX_SPLAT  (MAX_SPLAT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .depth_z_i        (depth_z_i),
    .splat_size_i     (splat_size_i),
    .normal_x_i       (normal_x_i),
    .normal_y_i       (normal_y_i),
    .normal_z_i       (normal_z_i),
    .has_color_i      (has_color_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .pixels_written_o (pixels_written_o),
    .rejected_o       (rejected_o),
    .pixel_color_o    (pixel_color_o),
    .pixel_depth_o    (pixel_depth_o)
  );

endmodule

// ----- sv/ssz_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssz_ctrl
// Sequencer: steps the datapath through clear, draw and read commands and
// owns the result beat valid.
// ----------------------------------------------------------------------------
module ssz_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       mode_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ssz_pkg::dp_cmd_t cmd_o,
  input  ssz_pkg::dp_sts_t sts_i
);
  import ssz_pkg::*;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_SPAN,
    ST_DOT_X,
    ST_DOT_Y,
    ST_DOT_Z,
    ST_DOT_SUM,
    ST_DIFF,
    ST_LIGHT,
    ST_CH_MUL,
    ST_CH_SCALE,
    ST_CH_SAT,
    ST_GREY_MUL,
    ST_GREY_SAT,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD,
    ST_FIN
  } state_e;

  state_e     state_q;
  logic       out_valid_q;
  logic [1:0] ch_q;
  logic       clr_cmd_q;
  dp_op_e     fin_op_q;
  logic       fin_go;

  // Result register free, or emptied at this edge
  assign fin_go      = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode state into a datapath command
  always_comb begin
    cmd_o.ch = ch_q;
    unique case (state_q)
      ST_CLR:      cmd_o.op = OP_CLR;
      ST_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_SPAN:     cmd_o.op = OP_SPAN;
      ST_DOT_X:    cmd_o.op = OP_DOT_X;
      ST_DOT_Y:    cmd_o.op = OP_DOT_Y;
      ST_DOT_Z:    cmd_o.op = OP_DOT_Z;
      ST_DOT_SUM:  cmd_o.op = OP_DOT_SUM;
      ST_DIFF:     cmd_o.op = OP_DIFF;
      ST_LIGHT:    cmd_o.op = OP_LIGHT;
      ST_CH_MUL:   cmd_o.op = OP_CH_MUL;
      ST_CH_SCALE: cmd_o.op = OP_CH_SCALE;
      ST_CH_SAT:   cmd_o.op = OP_CH_SAT;
      ST_GREY_MUL: cmd_o.op = OP_GREY_MUL;
      ST_GREY_SAT: cmd_o.op = OP_GREY_SAT;
      ST_PIX_RD:   cmd_o.op = OP_PIX_RD;
      ST_PIX_WR:   cmd_o.op = OP_PIX_WR;
      ST_RD:       cmd_o.op = OP_RD_ISSUE;
      ST_FIN:      cmd_o.op = fin_go ? fin_op_q : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      out_valid_q <= 1'b0;
      ch_q        <= 2'd0;
      clr_cmd_q   <= 1'b0;
      fin_op_q    <= OP_RES_ZERO;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLR: begin
          if (sts_i.clr_last) begin
            clr_cmd_q <= 1'b0;
            fin_op_q  <= OP_RES_ZERO;
            state_q   <= clr_cmd_q ? ST_FIN : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            unique case (mode_i)
              MODE_DRAW:  state_q <= ST_SPAN;
              MODE_READ:  state_q <= ST_RD;
              MODE_CLEAR: begin
                clr_cmd_q <= 1'b1;
                state_q   <= ST_CLR;
              end
              default: begin
                fin_op_q <= OP_RES_ZERO;
                state_q  <= ST_FIN;
              end
            endcase
          end
        end
        ST_SPAN:  state_q <= ST_DOT_X;
        ST_DOT_X: begin
          if (sts_i.rej) begin
            fin_op_q <= OP_RES_REJ;
            state_q  <= ST_FIN;
          end else begin
            state_q <= ST_DOT_Y;
          end
        end
        ST_DOT_Y:   state_q <= ST_DOT_Z;
        ST_DOT_Z:   state_q <= ST_DOT_SUM;
        ST_DOT_SUM: state_q <= ST_DIFF;
        ST_DIFF:    state_q <= ST_LIGHT;
        ST_LIGHT: begin
          ch_q    <= 2'd0;
          state_q <= sts_i.has_color ? ST_CH_MUL : ST_GREY_MUL;
        end
        ST_CH_MUL:   state_q <= ST_CH_SCALE;
        ST_CH_SCALE: state_q <= ST_CH_SAT;
        ST_CH_SAT: begin
          if (ch_q == CH_LAST) begin
            state_q <= ST_PIX_RD;
          end else begin
            ch_q    <= ch_q + 2'd1;
            state_q <= ST_CH_MUL;
          end
        end
        ST_GREY_MUL: state_q <= ST_GREY_SAT;
        ST_GREY_SAT: state_q <= ST_PIX_RD;
        ST_PIX_RD:   state_q <= ST_PIX_WR;
        ST_PIX_WR: begin
          if (sts_i.pix_last) begin
            fin_op_q <= OP_RES_CNT;
            state_q  <= ST_FIN;
          end else begin
            state_q <= ST_PIX_RD;
          end
        end
        ST_RD: begin
          fin_op_q <= OP_RES_RD;
          state_q  <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The last pixel of a span always ends the draw
  a_pix_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PIX_WR && sts_i.pix_last |=> state_q == ST_FIN)
    else $error("draw did not finish after last pixel");

  // Finishing raises the result beat
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && fin_go |=> out_valid_q)
    else $error("result beat not raised on finish");

  // No result is lost: finishing waits while an old beat is stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && state_q == ST_FIN |=> state_q == ST_FIN)
    else $error("result overwritten while stalled");

  // A clear pass never accepts an input beat
  a_clr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLR |-> in_stall_o)
    else $error("input accepted during clear pass");

endmodule

// ----- sv/ssz_dp.sv -----
// ----------------------------------------------------------------------------
// ssz_dp
// Datapath: configuration registers, span set-up, shared multiplier for
// lighting and colour, pixel stores and result register.
// ----------------------------------------------------------------------------
module ssz_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24,
  parameter int MAX_SPLAT  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  ssz_pkg::dp_cmd_t    cmd_i,
  output ssz_pkg::dp_sts_t    sts_o,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [24:0]  depth_z_i,
  input  logic [9:0]          splat_size_i,
  input  logic signed [15:0]  normal_x_i,
  input  logic signed [15:0]  normal_y_i,
  input  logic signed [15:0]  normal_z_i,
  input  logic                has_color_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic [10:0]         pixels_written_o,
  output logic                rejected_o,
  output logic [31:0]         pixel_color_o,
  output logic [23:0]         pixel_depth_o
);
  import ssz_pkg::*;

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int AW = XB + YB;
  localparam int MaxSs = MAX_SPLAT * 16;
  localparam logic [31:0] DepthMax = 32'((64'd1 << DEPTH_BITS) - 64'd1);

  // Configuration
  logic signed [15:0] lx_q, ly_q, lz_q;
  logic [8:0]         fw_q, fh_q;
  logic               flip_q;

  // Latched command fields
  logic signed [15:0] px_q, py_q, nx_q, ny_q, nz_q;
  logic signed [24:0] z_q;
  logic [9:0]         ss_q;
  logic               hc_q;
  logic [7:0]         r_q, g_q, b_q;

  // Working registers
  logic               rej_q;
  logic [XB-1:0]      sx_q, ex_q, cx_q;
  logic [YB-1:0]      ey_q, cy_q;
  logic [10:0]        cnt_q;
  logic signed [31:0] acc_q;
  logic [17:0]        light_q;
  logic [31:0]        col_q;
  logic signed [57:0] p_q;
  logic [AW-1:0]      clr_q;
  logic               rd_rej_q;
  logic [AW-1:0]      rd_addr_q;

  // Stores
  logic [31:0]           color_mem [2**AW];
  logic [DEPTH_BITS-1:0] depth_mem [2**AW];
  logic [31:0]           rcol_q;
  logic [DEPTH_BITS-1:0] rdep_q;

  // Result register
  logic [10:0] res_cnt_q;
  logic        res_rej_q;
  logic [31:0] res_col_q;
  logic [23:0] res_dep_q;

  // Span set-up signals
  logic [12:0]        w_c, h_c;
  logic signed [21:0] wm1, hm1, ys, px2, ys2, ssv;
  logic signed [21:0] sx_r, ex_r, sy_r, ey_r;
  logic signed [21:0] sx_c, ex_c, sy_c, ey_c;
  logic [10:0]        ssc;
  logic               span_off;

  // Read command signals
  logic signed [11:0] rx, ry;
  logic               rd_out;

  // Multiplier operands
  logic signed [31:0] mul_a;
  logic signed [25:0] mul_b;
  logic [7:0]         chan_in;
  logic [7:0]         sat8;

  // Pixel test and store ports
  logic [31:0]           z32, zsat;
  logic [DEPTH_BITS-1:0] zq;
  logic                  pass;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [31:0]           wcol;
  logic [DEPTH_BITS-1:0] wdep;
  logic [AW-1:0]         pix_addr;
  logic [31:0]           rdep32;

  // Clamp frame size to the store; a zero size becomes one
  always_comb begin
    if (fw_q == 9'd0) begin
      w_c = 13'd1;
    end else if ({4'd0, fw_q} > 13'(MAX_WIDTH)) begin
      w_c = 13'(MAX_WIDTH);
    end else begin
      w_c = {4'd0, fw_q};
    end
    if (fh_q == 9'd0) begin
      h_c = 13'd1;
    end else if ({4'd0, fh_q} > 13'(MAX_HEIGHT)) begin
      h_c = 13'(MAX_HEIGHT);
    end else begin
      h_c = {4'd0, fh_q};
    end
  end

  // Span ends in doubled Q.5 coordinates, floored by arithmetic shift
  always_comb begin
    wm1 = $signed({9'd0, w_c}) - 22'sd1;
    hm1 = $signed({9'd0, h_c}) - 22'sd1;
    ssc = ({1'b0, ss_q} > 11'(MaxSs)) ? 11'(MaxSs) : {1'b0, ss_q};
    ssv = $signed({11'd0, ssc});
    ys  = flip_q ? ($signed({5'd0, h_c, 4'd0}) - 22'(py_q)) : 22'(py_q);
    px2 = 22'(px_q) <<< 1;
    ys2 = ys <<< 1;
    sx_r = (px2 - ssv + 22'sd16) >>> 5;
    ex_r = (px2 + ssv + 22'sd16) >>> 5;
    sy_r = (ys2 - ssv + 22'sd16) >>> 5;
    ey_r = (ys2 + ssv + 22'sd16) >>> 5;
    span_off = (sx_r > wm1) || (ex_r < 22'sd0) || (sy_r > hm1) || (ey_r < 22'sd0);
    sx_c = (sx_r < 22'sd0) ? 22'sd0 : ((sx_r > wm1) ? wm1 : sx_r);
    ex_c = (ex_r < 22'sd0) ? 22'sd0 : ((ex_r > wm1) ? wm1 : ex_r);
    sy_c = (sy_r < 22'sd0) ? 22'sd0 : ((sy_r > hm1) ? hm1 : sy_r);
    ey_c = (ey_r < 22'sd0) ? 22'sd0 : ((ey_r > hm1) ? hm1 : ey_r);
  end

  // Read position: integer part of Q12.4
  assign rx     = 12'(px_q >>> 4);
  assign ry     = 12'(py_q >>> 4);
  assign rd_out = (rx < 12'sd0) || ($signed({1'b0, rx}) >= $signed(w_c)) ||
                  (ry < 12'sd0) || ($signed({1'b0, ry}) >= $signed(h_c));

  // Select operands for the shared multiplier
  always_comb begin
    unique case (cmd_i.ch)
      2'd0:    chan_in = r_q;
      2'd1:    chan_in = g_q;
      default: chan_in = b_q;
    endcase
    mul_a = 32'sd0;
    mul_b = 26'sd0;
    unique case (cmd_i.op)
      OP_DOT_X: begin
        mul_a = 32'(nx_q);
        mul_b = 26'(lx_q);
      end
      OP_DOT_Y: begin
        mul_a = 32'(ny_q);
        mul_b = 26'(ly_q);
      end
      OP_DOT_Z: begin
        mul_a = 32'(nz_q);
        mul_b = 26'(lz_q);
      end
      OP_DIFF: begin
        mul_a = acc_q[31] ? 32'sd0 : acc_q;
        mul_b = 26'(DIFFUSE_Q16);
      end
      OP_CH_MUL: begin
        mul_a = $signed({14'd0, light_q});
        mul_b = $signed({18'd0, chan_in});
      end
      OP_CH_SCALE: begin
        mul_a = $signed({6'd0, p_q[25:0]});
        mul_b = 26'(CHAN_SCALE);
      end
      OP_GREY_MUL: begin
        mul_a = $signed({14'd0, light_q});
        mul_b = 26'(GREY_SCALE);
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 26'sd0;
      end
    endcase
  end

  // Saturate the high word of a product to one byte
  assign sat8 = (|p_q[57:40]) ? 8'hFF : p_q[39:32];

  // Depth saturated to the store width
  assign z32      = {8'd0, z_q[23:0]};
  assign zsat     = (z32 > DepthMax) ? DepthMax : z32;
  assign zq       = zsat[DEPTH_BITS-1:0];
  assign pass     = zq < rdep_q;
  assign pix_addr = {cy_q, cx_q};

  // Store port muxing
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = pix_addr;
    raddr = pix_addr;
    wcol  = col_q;
    wdep  = zq;
    unique case (cmd_i.op)
      OP_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wcol  = 32'd0;
        wdep  = DepthMax[DEPTH_BITS-1:0];
      end
      OP_PIX_RD:   re = 1'b1;
      OP_PIX_WR:   we = pass;
      OP_RD_ISSUE: begin
        re    = 1'b1;
        raddr = {ry[YB-1:0], rx[XB-1:0]};
      end
      default: begin
        we = 1'b0;
        re = 1'b0;
      end
    endcase
  end

  // Colour and depth stores
  always_ff @(posedge clk_i) begin
    if (we) begin
      color_mem[waddr] <= wcol;
      depth_mem[waddr] <= wdep;
    end
    if (re) begin
      rcol_q <= color_mem[raddr];
      rdep_q <= depth_mem[raddr];
    end
  end

  assign rdep32 = 32'(rdep_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q   <= 16'sd0;
      ly_q   <= 16'sd0;
      lz_q   <= 16'sd16384;
      fw_q   <= 9'd256;
      fh_q   <= 9'd256;
      flip_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LIGHT_X: lx_q   <= cfg_data_i;
        CFG_LIGHT_Y: ly_q   <= cfg_data_i;
        CFG_LIGHT_Z: lz_q   <= cfg_data_i;
        CFG_FRAME_W: fw_q   <= cfg_data_i[8:0];
        CFG_FRAME_H: fh_q   <= cfg_data_i[8:0];
        CFG_FLIP_Y:  flip_q <= cfg_data_i[0];
        default:     flip_q <= flip_q;
      endcase
    end
  end

  // Clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.op == OP_CLR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    p_q <= 58'(mul_a) * 58'(mul_b);
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        px_q <= pos_x_i;
        py_q <= pos_y_i;
        z_q  <= depth_z_i;
        ss_q <= splat_size_i;
        nx_q <= normal_x_i;
        ny_q <= normal_y_i;
        nz_q <= normal_z_i;
        hc_q <= has_color_i;
        r_q  <= red_i;
        g_q  <= green_i;
        b_q  <= blue_i;
      end
      OP_SPAN: begin
        rej_q <= z_q[24] || span_off;
        sx_q  <= sx_c[XB-1:0];
        cx_q  <= sx_c[XB-1:0];
        ex_q  <= ex_c[XB-1:0];
        cy_q  <= sy_c[YB-1:0];
        ey_q  <= ey_c[YB-1:0];
        cnt_q <= 11'd0;
      end
      OP_DOT_Y:   acc_q <= 32'(p_q);
      OP_DOT_Z:   acc_q <= acc_q + 32'(p_q);
      OP_DOT_SUM: acc_q <= acc_q + 32'(p_q);
      OP_LIGHT: begin
        light_q <= AMBIENT_Q16 + p_q[45:28];
        col_q   <= 32'd0;
      end
      OP_CH_SAT: begin
        unique case (cmd_i.ch)
          2'd0:    col_q[7:0]   <= sat8;
          2'd1:    col_q[15:8]  <= sat8;
          default: col_q[23:16] <= sat8;
        endcase
      end
      OP_GREY_SAT: col_q <= {sat8, sat8, sat8, sat8};
      OP_PIX_WR: begin
        if (pass) begin
          cnt_q <= cnt_q + 11'd1;
        end
        if (cx_q == ex_q) begin
          cx_q <= sx_q;
          cy_q <= cy_q + 1'b1;
        end else begin
          cx_q <= cx_q + 1'b1;
        end
      end
      OP_RD_ISSUE: rd_rej_q <= rd_out;
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_RES_ZERO, OP_RES_REJ, OP_RES_CNT: begin
        res_cnt_q <= (cmd_i.op == OP_RES_CNT) ? cnt_q : 11'd0;
        res_rej_q <= (cmd_i.op == OP_RES_REJ);
        res_col_q <= 32'd0;
        res_dep_q <= 24'd0;
      end
      OP_RES_RD: begin
        res_cnt_q <= 11'd0;
        res_rej_q <= rd_rej_q;
        res_col_q <= rd_rej_q ? 32'd0 : rcol_q;
        res_dep_q <= rd_rej_q ? DepthMax[23:0] : rdep32[23:0];
      end
      default: begin
        res_rej_q <= res_rej_q;
      end
    endcase
  end

  assign pixels_written_o = res_cnt_q;
  assign rejected_o       = res_rej_q;
  assign pixel_color_o    = res_col_q;
  assign pixel_depth_o    = res_dep_q;

  assign sts_o.rej       = rej_q;
  assign sts_o.has_color = hc_q;
  assign sts_o.pix_last  = (cx_q == ex_q) && (cy_q == ey_q);
  assign sts_o.clr_last  = &clr_q;

endmodule
